// ===== rtl/core/rri_pkg.sv =====
// ----------------------------------------------------------------------------
// rri_pkg
// widths, codes and transaction types shared by the ray-ray intersection core
// ----------------------------------------------------------------------------
package rri_pkg;

	// field formats
	localparam int PW  = 32;       // position width, q15.16
	localparam int DW  = 16;       // direction width, q1.14
	localparam int F   = DW - 2;   // direction fraction bits
	localparam int PF  = 16;       // position fraction bits
	localparam int CW  = 32;       // register width
	localparam int IDXW = 2;       // register index width

	// internal widths
	localparam int ODW   = PW + 1;                 // origin difference
	localparam int N1W   = 2 * DW + 1;             // direction cross
	localparam int N2W   = ODW + DW + 1;           // offset cross
	localparam int N2L   = N2W / 2;                // low split of offset cross
	localparam int N2H   = N2W - N2L;              // high split of offset cross
	localparam int MW    = 2 * N1W;                // squared length of direction cross
	localparam int SQLW  = 2 * N2W;                // one lane of offset squared length
	localparam int SQW   = 2 * N2W + 2;            // offset squared length
	localparam int DOLW  = N2W + N1W;              // one lane of the cross dot
	localparam int DOTW  = N2W + N1W + 2;          // cross dot
	localparam int TPW   = N2W + DW + 2;           // triple product
	localparam int MAGW  = DOTW;                   // magnitude of cross dot
	localparam int CKW   = (MAGW + 2) / 3;         // chunk of magnitude per multiplier
	localparam int PRODW = MAGW + DW;              // dividend
	localparam int QW    = PW + 1;                 // quotient bits kept
	localparam int RW    = (PRODW > MW + QW) ? PRODW : MW + QW;   // remainder

	// register indexes
	localparam logic [IDXW-1:0] REG_PARALLEL = 2'd0;
	localparam logic [IDXW-1:0] REG_OVERLAP  = 2'd1;
	localparam logic [IDXW-1:0] REG_COPLANAR = 2'd2;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_OVERLAP  = 2'd1,
		ST_PARALLEL = 2'd2,
		ST_SKEW     = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [PW-1:0] origin_a_x;
		logic signed [PW-1:0] origin_a_y;
		logic signed [PW-1:0] origin_a_z;
		logic signed [DW-1:0] dir_a_x;
		logic signed [DW-1:0] dir_a_y;
		logic signed [DW-1:0] dir_a_z;
		logic signed [PW-1:0] origin_b_x;
		logic signed [PW-1:0] origin_b_y;
		logic signed [PW-1:0] origin_b_z;
		logic signed [DW-1:0] dir_b_x;
		logic signed [DW-1:0] dir_b_y;
		logic signed [DW-1:0] dir_b_z;
	} rri_in_t;

	typedef struct packed {
		status_t              status;
		logic signed [PW-1:0] point_x;
		logic signed [PW-1:0] point_y;
		logic signed [PW-1:0] point_z;
	} rri_out_t;

	typedef struct packed {
		logic [CW-1:0] par_thr;
		logic [CW-1:0] ovl_thr;
		logic [CW-1:0] cop_tol;
	} rri_cfg_t;

	typedef struct packed {
		logic par;
		logic ovl;
		logic skw;
	} rri_ctl_t;

	typedef struct packed {
		logic [MW-1:0]           m;
		logic [2:0][PRODW-1:0]   prod;
		rri_ctl_t                ctl;
		logic [2:0]              neg;
		logic [2:0][PW-1:0]      oa;
	} rri_geo_t;

	typedef struct packed {
		logic [MW-1:0]           m;
		logic [2:0][RW-1:0]      rem;
		logic [2:0][QW-1:0]      quo;
		rri_ctl_t                ctl;
		logic [2:0]              neg;
		logic [2:0]              ovf;
		logic [2:0][PW-1:0]      oa;
	} rri_div_t;

endpackage

// ===== rtl/core/ray_ray_intersection_core.sv =====
// ----------------------------------------------------------------------------
// ray_ray_intersection_core
// intersection of two 3d rays in fixed point, one ray pair per unstalled clock
//
// takes one ray pair per unstalled cycle and returns one result per pair, in
// order, via eight geometry stages (cross products, squared lengths and the
// threshold tests, then the dividend), one stage that checks the quotient for
// overflow, 33 restoring division steps (one quotient bit per stage for all
// three axes at once) and one stage for the final add, clamp and status. the
// divider chain sets the depth; throughput is one transaction per unstalled
// cycle. a one-entry skid buffer sits at the input so a transaction is still
// taken in the cycle the output stalls; in_stall is a register. the three
// threshold registers may only be written while the core is empty
// ----------------------------------------------------------------------------
module ray_ray_intersection_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  rri_pkg::rri_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output rri_pkg::rri_out_t          out_data,
	input  logic                       wr_en,
	input  logic [rri_pkg::IDXW-1:0]   wr_index,
	input  logic [rri_pkg::CW-1:0]     wr_data
);
	import rri_pkg::*;

	// whole pipe advances together unless a finished result is held
	logic en;

	// input skid buffer
	logic    acc;
	logic    skid_v_q;
	rri_in_t skid_q;
	logic    feed_v;
	rri_in_t feed_d;

	// threshold registers
	logic [CW-1:0] par_thr_q, ovl_thr_q, cop_tol_q;
	rri_cfg_t      cfg;

	// geometry front end
	logic     geo_v;
	rri_geo_t geo;

	// overflow check and divider entry
	rri_div_t ent_d9, div_s9;
	logic     v_s9;

	// divider chain
	logic     dv_v [QW+1];
	rri_div_t dv   [QW+1];

	// final stage
	rri_out_t out_d10, out_s10;
	logic     out_v_s10;

	localparam logic signed [PW+2:0] SMAX = {{4{1'b0}}, {(PW-1){1'b1}}};
	localparam logic signed [PW+2:0] SMIN = {{4{1'b1}}, {(PW-1){1'b0}}};
	localparam logic [PW-1:0]        PMAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic [PW-1:0]        PMIN = {1'b1, {(PW-1){1'b0}}};

	assign en       = !out_v_s10 || !out_stall;
	assign in_stall = skid_v_q;
	assign acc      = in_valid && !skid_v_q;
	assign feed_v   = skid_v_q || acc;
	assign feed_d   = skid_v_q ? skid_q : in_data;

	// skid holds a transaction taken while the pipe is frozen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (acc && !en) begin
			skid_v_q <= 1'b1;
		end else if (en) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !en) begin
			skid_q <= in_data;
		end
	end

	// configuration writes, unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_thr_q <= CW'(1);
			ovl_thr_q <= CW'(1);
			cop_tol_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PARALLEL: par_thr_q <= wr_data;
				REG_OVERLAP:  ovl_thr_q <= wr_data;
				REG_COPLANAR: cop_tol_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg.par_thr = par_thr_q;
	assign cfg.ovl_thr = ovl_thr_q;
	assign cfg.cop_tol = cop_tol_q;

	rri_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (feed_v),
		.d_in   (feed_d),
		.cfg    (cfg),
		.v_out  (geo_v),
		.g_out  (geo)
	);

	// quotient overflow: dividend at or above m * 2^QW saturates the point
	always_comb begin
		logic [RW-1:0] lim;
		lim        = RW'(geo.m) << QW;
		ent_d9.m   = geo.m;
		ent_d9.ctl = geo.ctl;
		ent_d9.neg = geo.neg;
		ent_d9.oa  = geo.oa;
		ent_d9.quo = '0;
		for (int i = 0; i < 3; i++) begin
			ent_d9.rem[i] = RW'(geo.prod[i]);
			ent_d9.ovf[i] = RW'(geo.prod[i]) >= lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= geo_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s9 <= ent_d9;
		end
	end

	assign dv_v[0] = v_s9;
	assign dv[0]   = div_s9;

	// quotient bits from the top down, one per stage
	for (genvar g = 0; g < QW; g++) begin : g_div
		rri_div_step #(
			.BIT (QW - 1 - g)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (dv_v[g]),
			.d_in   (dv[g]),
			.v_out  (dv_v[g+1]),
			.d_out  (dv[g+1])
		);
	end

	// origin plus signed offset, clamped, and the status code
	always_comb begin
		rri_div_t              r;
		logic signed [PW+2:0]  oas, qs, sum;
		logic [2:0][PW-1:0]    pts;
		r = dv[QW];
		for (int i = 0; i < 3; i++) begin
			oas = (PW + 3)'($signed(r.oa[i]));
			qs  = $signed((PW + 3)'(r.quo[i]));
			sum = r.neg[i] ? (oas - qs) : (oas + qs);
			if (r.ctl.par) begin
				pts[i] = r.ctl.ovl ? r.oa[i] : '0;
			end else if (r.ovf[i]) begin
				pts[i] = r.neg[i] ? PMIN : PMAX;
			end else if (sum > SMAX) begin
				pts[i] = PMAX;
			end else if (sum < SMIN) begin
				pts[i] = PMIN;
			end else begin
				pts[i] = sum[PW-1:0];
			end
		end
		if (r.ctl.par) begin
			out_d10.status = r.ctl.ovl ? ST_OVERLAP : ST_PARALLEL;
		end else begin
			out_d10.status = r.ctl.skw ? ST_SKEW : ST_HIT;
		end
		out_d10.point_x = pts[0];
		out_d10.point_y = pts[1];
		out_d10.point_z = pts[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s10 <= 1'b0;
		end else if (en) begin
			out_v_s10 <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s10 <= out_d10;
		end
	end

	assign out_valid = out_v_s10;
	assign out_data  = out_s10;

	// a transaction taken while frozen lands in the skid buffer
	a_skid_fill : assert property (@(posedge clk) disable iff (!arst_n)
		acc && !en |=> skid_v_q)
		else $error("transaction taken during stall not held in skid");

	// the skid entry is kept intact until the pipe moves
	a_skid_hold : assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !en |=> skid_v_q && $stable(skid_q))
		else $error("skid entry lost while pipe frozen");

	// parallel rays without overlap report the zero point
	a_par_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_PARALLEL |->
			out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0)
		else $error("parallel result with nonzero point");

endmodule

// ===== rtl/core/rri_geom.sv =====
// ----------------------------------------------------------------------------
// rri_geom
// cross products, squared lengths, threshold tests and scaled dividend
// ----------------------------------------------------------------------------
module rri_geom (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_in,
	input  rri_pkg::rri_in_t  d_in,
	input  rri_pkg::rri_cfg_t cfg,
	output logic              v_out,
	output rri_pkg::rri_geo_t g_out
);
	import rri_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// stage 1: unpack, origin difference
	logic [2:0][PW-1:0]  oa_d1, ob_d1;
	logic [2:0][DW-1:0]  da_d1, db_d1;
	logic [2:0][ODW-1:0] od_d1;
	logic [2:0][PW-1:0]  oa_s1;
	logic [2:0][DW-1:0]  da_s1, db_s1;
	logic [2:0][ODW-1:0] od_s1;

	// stage 2: cross products
	logic [2:0][N1W-1:0] n1_d2, n1_s2;
	logic [2:0][N2W-1:0] n2_d2, n2_s2;
	logic [2:0][PW-1:0]  oa_s2;
	logic [2:0][DW-1:0]  da_s2;

	// stage 3: partial products
	logic [2:0][2*N1W-1:0]     n1sq_d3, n1sq_s3;
	logic [2:0][2*N2H-1:0]     hh_d3, hh_s3;
	logic [2:0][N2H+N2L:0]     hl_d3, hl_s3;
	logic [2:0][2*N2L-1:0]     ll_d3, ll_s3;
	logic [2:0][N2H+N1W-1:0]   dh_d3, dh_s3;
	logic [2:0][N2L+N1W:0]     dl_d3, dl_s3;
	logic [2:0][N2W+DW-1:0]    tpp_d3, tpp_s3;
	logic [2:0][PW-1:0]        oa_s3;
	logic [2:0][DW-1:0]        da_s3;

	// stage 4: lane sums
	logic [2:0][SQLW-1:0] sql_d4, sql_s4;
	logic [2:0][DOLW-1:0] dotl_d4, dotl_s4;
	logic [MW-1:0]        m_d4, m_s4;
	logic [TPW-1:0]       tp_d4, tp_s4;
	logic [2:0][PW-1:0]   oa_s4;
	logic [2:0][DW-1:0]   da_s4;

	// stage 5: cross-lane sums, parallel and skew tests
	logic [SQW-1:0]       sq_d5, sq_s5;
	logic [DOTW-1:0]      dot_d5, dot_s5;
	logic                 par_d5, skw_d5, par_s5, skw_s5;
	logic [MW-1:0]        m_s5;
	logic [2:0][PW-1:0]   oa_s5;
	logic [2:0][DW-1:0]   da_s5;

	// stage 6: overlap test, magnitude of cross dot
	logic                 ovl_d6, dneg_d6, ovl_s6, dneg_s6, par_s6, skw_s6;
	logic [MAGW-1:0]      mag_d6, mag_s6;
	logic [MW-1:0]        m_s6;
	logic [2:0][PW-1:0]   oa_s6;
	logic [2:0][DW-1:0]   da_s6;

	// stage 7: dividend partial products
	logic [2:0][2:0][CKW+DW-1:0] pp_d7, pp_s7;
	logic [2:0]                  neg_d7, neg_s7;
	rri_ctl_t                    ctl_s7;
	logic [MW-1:0]               m_s7;
	logic [2:0][PW-1:0]          oa_s7;

	// stage 8: dividend
	rri_geo_t g_d8, g_s8;

	always_comb begin : c_s1
		oa_d1[0] = d_in.origin_a_x;
		oa_d1[1] = d_in.origin_a_y;
		oa_d1[2] = d_in.origin_a_z;
		ob_d1[0] = d_in.origin_b_x;
		ob_d1[1] = d_in.origin_b_y;
		ob_d1[2] = d_in.origin_b_z;
		da_d1[0] = d_in.dir_a_x;
		da_d1[1] = d_in.dir_a_y;
		da_d1[2] = d_in.dir_a_z;
		db_d1[0] = d_in.dir_b_x;
		db_d1[1] = d_in.dir_b_y;
		db_d1[2] = d_in.dir_b_z;
		for (int i = 0; i < 3; i++) begin
			od_d1[i] = ODW'($signed(ob_d1[i])) - ODW'($signed(oa_d1[i]));
		end
	end

	always_comb begin : c_s2
		logic [1:0]                j, k;
		logic signed [2*DW-1:0]    pa, pb;
		logic signed [ODW+DW-1:0]  qa, qb;
		for (int i = 0; i < 3; i++) begin
			j = (i == 2) ? 2'd0 : 2'(i + 1);
			k = (i == 0) ? 2'd2 : 2'(i - 1);
			pa = $signed(da_s1[j]) * $signed(db_s1[k]);
			pb = $signed(da_s1[k]) * $signed(db_s1[j]);
			qa = $signed(od_s1[j]) * $signed(db_s1[k]);
			qb = $signed(od_s1[k]) * $signed(db_s1[j]);
			n1_d2[i] = N1W'(pa) - N1W'(pb);
			n2_d2[i] = N2W'(qa) - N2W'(qb);
		end
	end

	always_comb begin : c_s3
		logic signed [N2H-1:0] n2h;
		logic [N2L-1:0]        n2l;
		for (int i = 0; i < 3; i++) begin
			n2h = $signed(n2_s2[i][N2W-1:N2L]);
			n2l = n2_s2[i][N2L-1:0];
			n1sq_d3[i] = $signed(n1_s2[i]) * $signed(n1_s2[i]);
			hh_d3[i]   = n2h * n2h;
			hl_d3[i]   = n2h * $signed({1'b0, n2l});
			ll_d3[i]   = n2l * n2l;
			dh_d3[i]   = n2h * $signed(n1_s2[i]);
			dl_d3[i]   = $signed({1'b0, n2l}) * $signed(n1_s2[i]);
			tpp_d3[i]  = $signed(n2_s2[i]) * $signed(da_s2[i]);
		end
	end

	always_comb begin : c_s4
		m_d4  = '0;
		tp_d4 = '0;
		for (int i = 0; i < 3; i++) begin
			sql_d4[i] = (SQLW'($signed(hh_s3[i])) <<< (2 * N2L))
				+ (SQLW'($signed(hl_s3[i])) <<< (N2L + 1))
				+ SQLW'($signed({1'b0, ll_s3[i]}));
			dotl_d4[i] = (DOLW'($signed(dh_s3[i])) <<< N2L) + DOLW'($signed(dl_s3[i]));
			m_d4  = m_d4 + MW'(n1sq_s3[i]);
			tp_d4 = tp_d4 + TPW'($signed(tpp_s3[i]));
		end
	end

	always_comb begin : c_s5
		logic [TPW-1:0] tpa;
		sq_d5  = '0;
		dot_d5 = '0;
		for (int i = 0; i < 3; i++) begin
			sq_d5  = sq_d5 + SQW'($signed(sql_s4[i]));
			dot_d5 = dot_d5 + DOTW'($signed(dotl_s4[i]));
		end
		// exactly zero cross is parallel whatever the threshold
		par_d5 = (m_s4 == '0) || (m_s4 < (MW'(cfg.par_thr) << (2 * F)));
		tpa    = tp_s4[TPW-1] ? (TPW'(0) - tp_s4) : tp_s4;
		skw_d5 = tpa > (TPW'(cfg.cop_tol) << (2 * F));
	end

	always_comb begin : c_s6
		ovl_d6  = sq_s5 < (SQW'(cfg.ovl_thr) << (PF + 2 * F));
		dneg_d6 = dot_s5[DOTW-1];
		mag_d6  = dneg_d6 ? (MAGW'(0) - dot_s5) : dot_s5;
	end

	always_comb begin : c_s7
		logic [3*CKW-1:0] magx;
		logic [DW-1:0]    dm;
		magx = (3 * CKW)'(mag_s6);
		for (int i = 0; i < 3; i++) begin
			neg_d7[i] = dneg_s6 ^ da_s6[i][DW-1];
			dm = da_s6[i][DW-1] ? (DW'(0) - da_s6[i]) : da_s6[i];
			for (int c = 0; c < 3; c++) begin
				pp_d7[i][c] = magx[c*CKW +: CKW] * dm;
			end
		end
	end

	always_comb begin : c_s8
		g_d8.m   = m_s7;
		g_d8.ctl = ctl_s7;
		g_d8.neg = neg_s7;
		g_d8.oa  = oa_s7;
		for (int i = 0; i < 3; i++) begin
			g_d8.prod[i] = PRODW'(pp_s7[i][0])
				+ (PRODW'(pp_s7[i][1]) << CKW)
				+ (PRODW'(pp_s7[i][2]) << (2 * CKW));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oa_s1 <= oa_d1;
			da_s1 <= da_d1;
			db_s1 <= db_d1;
			od_s1 <= od_d1;

			n1_s2 <= n1_d2;
			n2_s2 <= n2_d2;
			oa_s2 <= oa_s1;
			da_s2 <= da_s1;

			n1sq_s3 <= n1sq_d3;
			hh_s3   <= hh_d3;
			hl_s3   <= hl_d3;
			ll_s3   <= ll_d3;
			dh_s3   <= dh_d3;
			dl_s3   <= dl_d3;
			tpp_s3  <= tpp_d3;
			oa_s3   <= oa_s2;
			da_s3   <= da_s2;

			sql_s4  <= sql_d4;
			dotl_s4 <= dotl_d4;
			m_s4    <= m_d4;
			tp_s4   <= tp_d4;
			oa_s4   <= oa_s3;
			da_s4   <= da_s3;

			sq_s5  <= sq_d5;
			dot_s5 <= dot_d5;
			par_s5 <= par_d5;
			skw_s5 <= skw_d5;
			m_s5   <= m_s4;
			oa_s5  <= oa_s4;
			da_s5  <= da_s4;

			ovl_s6  <= ovl_d6;
			dneg_s6 <= dneg_d6;
			mag_s6  <= mag_d6;
			par_s6  <= par_s5;
			skw_s6  <= skw_s5;
			m_s6    <= m_s5;
			oa_s6   <= oa_s5;
			da_s6   <= da_s5;

			pp_s7      <= pp_d7;
			neg_s7     <= neg_d7;
			ctl_s7.par <= par_s6;
			ctl_s7.ovl <= ovl_s6;
			ctl_s7.skw <= skw_s6;
			m_s7       <= m_s6;
			oa_s7      <= oa_s6;

			g_s8 <= g_d8;
		end
	end

	assign v_out = v_s8;
	assign g_out = g_s8;

endmodule

// ===== rtl/core/rri_div_step.sv =====
// ----------------------------------------------------------------------------
// rri_div_step
// one restoring division step for all three lanes, one quotient bit each
// ----------------------------------------------------------------------------
module rri_div_step #(
	parameter int BIT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_in,
	input  rri_pkg::rri_div_t d_in,
	output logic              v_out,
	output rri_pkg::rri_div_t d_out
);
	import rri_pkg::*;

	logic     v_s1;
	rri_div_t d_d, d_s1;

	always_comb begin
		logic [RW-1:0] dsh;
		d_d = d_in;
		dsh = RW'(d_in.m) << BIT;
		for (int i = 0; i < 3; i++) begin
			if (d_in.rem[i] >= dsh) begin
				d_d.rem[i]      = d_in.rem[i] - dsh;
				d_d.quo[i][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_d;
		end
	end

	assign v_out = v_s1;
	assign d_out = d_s1;

endmodule

// ===== test/tb_ray_ray_intersection_core.sv =====
// ----------------------------------------------------------------------------
// tb_ray_ray_intersection_core
// self-checking testbench for the ray-ray intersection core
//
// a short table of directed ray pairs is followed by random pairs under five
// threshold settings (reset values, all zero, all ones, narrow and fully
// random). each accepted pair without a known result runs through an exact
// wide-integer intersection model; each result transaction is compared field by
// field with the oldest expected point. both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_ray_ray_intersection_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rri_pkg::*;

	localparam int DRAIN_CYCLES  = 60;    // margin over the core pipeline depth
	localparam int STALL_LIMIT   = 2000;  // cycles without any transaction
	localparam int PHASE_PAIRS   = 350;

	typedef struct {
		rri_in_t  pair;
		bit       known;     // result typed in below rather than predicted
		rri_out_t result;
	} pair_row_t;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	rri_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	rri_out_t out_data;
	logic     wr_en;
	logic [IDXW-1:0] wr_index;
	logic [CW-1:0]   wr_data;

	// testbench copy of the threshold registers
	logic [CW-1:0] cfg_parallel;
	logic [CW-1:0] cfg_overlap;
	logic [CW-1:0] cfg_coplanar;

	rri_out_t  pending_points[$];
	pair_row_t directed_pairs[$];
	int        errors;
	int        quiet_cycles;
	bit        no_idle;       // run both sides back to back
	bit        rx_took;
	int        rx_hold;

	ray_ray_intersection_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// exact intersection point: every product is held in 128 bits, only the
	// division of the offset truncates toward zero
	function automatic rri_out_t intersect_rays(rri_in_t p);
		logic signed [127:0] oa[3], da[3], ob[3], db[3], od[3], n1[3], n2[3];
		logic signed [127:0] m, sq, dot, tp, off, sum, lim;
		logic [127:0] mag, dm, q, atp;
		logic [PW-1:0] pt[3];
		status_t st;
		rri_out_t r;
		bit neg;
		int j, k;
		oa[0] = p.origin_a_x; oa[1] = p.origin_a_y; oa[2] = p.origin_a_z;
		ob[0] = p.origin_b_x; ob[1] = p.origin_b_y; ob[2] = p.origin_b_z;
		da[0] = p.dir_a_x;    da[1] = p.dir_a_y;    da[2] = p.dir_a_z;
		db[0] = p.dir_b_x;    db[1] = p.dir_b_y;    db[2] = p.dir_b_z;
		for (int i = 0; i < 3; i++) od[i] = ob[i] - oa[i];
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			n1[i] = da[j] * db[k] - da[k] * db[j];
			n2[i] = od[j] * db[k] - od[k] * db[j];
		end
		m = n1[0] * n1[0] + n1[1] * n1[1] + n1[2] * n1[2];
		lim = {96'd0, cfg_parallel};
		lim = lim << (2 * F);
		// an exactly zero cross counts as parallel whatever the threshold
		if (m == 0 || m < lim) begin
			sq = n2[0] * n2[0] + n2[1] * n2[1] + n2[2] * n2[2];
			lim = {96'd0, cfg_overlap};
			lim = lim << (PF + 2 * F);
			if (sq < lim) begin
				st = ST_OVERLAP;
				for (int i = 0; i < 3; i++) pt[i] = oa[i][PW-1:0];
			end else begin
				st = ST_PARALLEL;
				for (int i = 0; i < 3; i++) pt[i] = '0;
			end
		end else begin
			dot = n2[0] * n1[0] + n2[1] * n1[1] + n2[2] * n1[2];
			tp  = n2[0] * da[0] + n2[1] * da[1] + n2[2] * da[2];
			mag = (dot < 0) ? -dot : dot;
			for (int i = 0; i < 3; i++) begin
				dm  = (da[i] < 0) ? -da[i] : da[i];
				q   = (mag * dm) / m;
				neg = (dot < 0) != (da[i] < 0);
				if ((q >> (PW + 1)) != 0) begin
					// far beyond range: saturate without adding the origin
					pt[i] = neg ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
				end else begin
					off = q;
					if (neg) off = -off;
					sum = oa[i] + off;
					if (sum > 128'sh7fffffff) pt[i] = {1'b0, {(PW-1){1'b1}}};
					else if (sum < -128'sh80000000) pt[i] = {1'b1, {(PW-1){1'b0}}};
					else pt[i] = sum[PW-1:0];
				end
			end
			atp = (tp < 0) ? -tp : tp;
			st = (atp > ({96'd0, cfg_coplanar} << (2 * F))) ? ST_SKEW : ST_HIT;
		end
		r.status  = st;
		r.point_x = pt[0];
		r.point_y = pt[1];
		r.point_z = pt[2];
		return r;
	endfunction

	// one of min, max, zero, minus one, one at the given width
	function automatic logic [31:0] edge_value(int w);
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0: v = 32'd1 << (w - 1);
			1: v = (32'd1 << (w - 1)) - 1;
			2: v = '0;
			3: v = '1;
			default: v = 32'd1;
		endcase
		return v;
	endfunction

	function automatic logic signed [DW-1:0] rand_dir();
		return DW'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// random ray pair; most are shaped to reach hits, overlaps and skews
	function automatic rri_in_t make_ray_pair();
		rri_in_t p;
		longint pos[3], da[3], db[3], oa[3], ob[3];
		longint a, b;
		int kind, axis;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom};
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			pos[i] = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
			da[i] = longint'(rand_dir());
			db[i] = longint'(rand_dir());
			oa[i] = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
			ob[i] = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
		end
		a = longint'($urandom_range(0, 127));
		b = longint'($urandom_range(0, 127));
		case (kind)
			0, 1: return p;
			4, 5: begin
				// both rays pass through one point
				for (int i = 0; i < 3; i++) begin
					oa[i] = pos[i] - ((a * da[i]) <<< 2);
					ob[i] = pos[i] - ((b * db[i]) <<< 2);
				end
			end
			6, 7: begin
				// parallel or antiparallel, on the same line or beside it
				for (int i = 0; i < 3; i++) begin
					db[i] = (b[0]) ? -da[i] : da[i];
					ob[i] = oa[i] + ((a * da[i]) <<< 2);
					if (kind == 7) ob[i] = ob[i] + longint'($urandom_range(0, 3));
				end
			end
			8: begin
				// axis aligned unit directions
				axis = $urandom_range(0, 2);
				for (int i = 0; i < 3; i++) begin
					da[i] = (i == axis) ? (a[0] ? -16384 : 16384) : 0;
					db[i] = (i == (axis + 1) % 3) ? (b[0] ? -16384 : 16384) : 0;
				end
				if (a[1]) ob[axis] = oa[axis];
			end
			9: begin
				p.origin_a_x = edge_value(PW); p.origin_a_y = edge_value(PW);
				p.origin_a_z = edge_value(PW); p.origin_b_x = edge_value(PW);
				p.origin_b_y = edge_value(PW); p.origin_b_z = edge_value(PW);
				p.dir_a_x = DW'(edge_value(DW)); p.dir_a_y = DW'(edge_value(DW));
				p.dir_a_z = DW'(edge_value(DW)); p.dir_b_x = DW'(edge_value(DW));
				p.dir_b_y = DW'(edge_value(DW)); p.dir_b_z = DW'(edge_value(DW));
				return p;
			end
			default: ;
		endcase
		p.origin_a_x = PW'(oa[0]); p.origin_a_y = PW'(oa[1]); p.origin_a_z = PW'(oa[2]);
		p.origin_b_x = PW'(ob[0]); p.origin_b_y = PW'(ob[1]); p.origin_b_z = PW'(ob[2]);
		p.dir_a_x = DW'(da[0]); p.dir_a_y = DW'(da[1]); p.dir_a_z = DW'(da[2]);
		p.dir_b_x = DW'(db[0]); p.dir_b_y = DW'(db[1]); p.dir_b_z = DW'(db[2]);
		return p;
	endfunction

	function automatic rri_in_t ray_pair(logic [PW-1:0] ax, ay, az, logic [DW-1:0] dax, day,
		daz, logic [PW-1:0] bx, by, bz, logic [DW-1:0] dbx, dby, dbz);
		return {ax, ay, az, dax, day, daz, bx, by, bz, dbx, dby, dbz};
	endfunction

	task automatic add_row(rri_in_t p, bit known, rri_out_t r);
		pair_row_t row;
		row.pair = p;
		row.known = known;
		row.result = r;
		directed_pairs.push_back(row);
	endtask

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_ray_pair(rri_in_t p, bit known, rri_out_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			in_valid = 1'b0;
			in_data = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = p;
		do @(posedge clk); while (in_stall);
		pending_points.push_back(known ? r : intersect_rays(p));
		@(negedge clk);
	endtask

	// wait until the core is empty, including its pipeline
	task automatic drain_core();
		in_valid = 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDXW-1:0] idx, logic [CW-1:0] value);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = value;
		case (idx)
			REG_PARALLEL: cfg_parallel = value;
			REG_OVERLAP:  cfg_overlap = value;
			REG_COPLANAR: cfg_coplanar = value;
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic run_random_pairs(int count);
		rri_out_t none;
		none = '0;
		for (int i = 0; i < count; i++) begin
			no_idle = (i < 40);
			// once per setting the sender holds off until the core is empty
			if (i == count / 2) begin
				in_valid = 1'b0;
				while (pending_points.size() != 0) @(negedge clk);
			end
			send_ray_pair(make_ray_pair(), 1'b0, none);
		end
		in_valid = 1'b0;
	endtask

	// receiver: random stall per result transaction
	always @(negedge clk) begin
		if (rx_took) begin
			rx_took = 1'b0;
			rx_hold = no_idle ? 0 : $urandom_range(0, 7);
		end
		out_stall <= (rx_hold != 0);
		if (rx_hold != 0) rx_hold--;
	end

	// result checker
	always @(posedge clk) begin
		rri_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			rx_took = 1'b1;
			if (pending_points.size() == 0) begin
				$error("result transaction with nothing expected: %h", out_data);
				errors++;
			end else begin
				want = pending_points.pop_front();
				if (out_data.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, out_data.status);
					errors++;
				end
				if (out_data.point_x !== want.point_x) begin
					$error("point_x expected %h actual %h", want.point_x, out_data.point_x);
					errors++;
				end
				if (out_data.point_y !== want.point_y) begin
					$error("point_y expected %h actual %h", want.point_y, out_data.point_y);
					errors++;
				end
				if (out_data.point_z !== want.point_z) begin
					$error("point_z expected %h actual %h", want.point_z, out_data.point_z);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_ray_ray_intersection_core failed");
			$finish;
		end
	end

	initial begin
		rri_out_t r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		errors = 0;
		quiet_cycles = 0;
		no_idle = 1'b1;
		rx_took = 1'b0;
		rx_hold = 0;
		cfg_parallel = 32'd1;
		cfg_overlap = 32'd1;
		cfg_coplanar = 32'd0;

		// all zero: zero cross product, zero offset, overlap at origin a
		r = '{ST_OVERLAP, 32'd0, 32'd0, 32'd0};
		add_row('0, 1'b1, r);
		// x and y axes from the origin meet at the origin
		r = '{ST_HIT, 32'd0, 32'd0, 32'd0};
		add_row(ray_pair(0, 0, 0, 16'sd16384, 0, 0, 0, 0, 0, 0, 16'sd16384, 0), 1'b1, r);
		// parallel x rays one unit apart never meet
		r = '{ST_PARALLEL, 32'd0, 32'd0, 32'd0};
		add_row(ray_pair(0, 0, 0, 16'sd16384, 0, 0, 0, 32'h10000, 0, 16'sd16384, 0, 0),
			1'b1, r);
		// parallel on one line, point is origin a
		r = '{ST_OVERLAP, 32'h30000, 32'h50000, 32'hfff90000};
		add_row(ray_pair(32'h30000, 32'h50000, 32'hfff90000, 0, 0, 16'sd16384,
			32'h30000, 32'h50000, 32'h20000, 0, 0, -16'sd16384), 1'b1, r);
		// skew lines, one unit apart in z
		add_row(ray_pair(0, 0, 0, 16'sd16384, 0, 0, 32'h50000, 0, 32'h10000,
			0, 16'sd16384, 0), 1'b0, r);
		// hit away from both origins
		add_row(ray_pair(32'hfffb0000, 0, 0, 16'sd16384, 0, 0, 32'h20000, 32'hfff00000, 0,
			0, 16'sd16384, 0), 1'b0, r);
		// field extremes, saturation and non-unit directions
		add_row(ray_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff,
			16'h7fff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff,
			16'h7fff), 1'b0, r);
		add_row(ray_pair(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000,
			16'h8000, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000,
			16'h8000), 1'b0, r);
		add_row(ray_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h8000, 16'h7fff,
			16'h8000, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'h7fff, 16'h8000,
			16'h0001), 1'b0, r);
		add_row(ray_pair(32'h7fff0000, 32'h7fff0000, 0, 16'sd16384, 16'sd1, 0,
			32'h80000000, 0, 0, 16'sd1, 16'sd16384, 0), 1'b0, r);
		add_row(ray_pair(0, 0, 0, 16'sd1, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			0, 16'sd1, 16'sd1), 1'b0, r);
		add_row(ray_pair('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 16'sd1, '1), 1'b0, r);
		for (int i = 0; i < 8; i++) add_row(make_ray_pair(), 1'b0, r);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset thresholds
		foreach (directed_pairs[i])
			send_ray_pair(directed_pairs[i].pair, directed_pairs[i].known,
				directed_pairs[i].result);
		in_valid = 1'b0;
		run_random_pairs(PHASE_PAIRS);

		// every register zero: only an exactly zero cross is parallel
		drain_core();
		write_reg(REG_PARALLEL, '0);
		write_reg(REG_OVERLAP, '0);
		write_reg(REG_COPLANAR, '0);
		run_random_pairs(PHASE_PAIRS);

		// every register at its top: most pairs parallel and overlapping
		drain_core();
		write_reg(REG_PARALLEL, '1);
		write_reg(REG_OVERLAP, '1);
		write_reg(REG_COPLANAR, '1);
		run_random_pairs(PHASE_PAIRS);

		// narrow thresholds around the interesting boundaries
		drain_core();
		write_reg(REG_PARALLEL, $urandom_range(0, 4096));
		write_reg(REG_OVERLAP, $urandom_range(0, 1 << 20));
		write_reg(REG_COPLANAR, $urandom_range(0, 1 << 16));
		run_random_pairs(PHASE_PAIRS);

		// fully random thresholds
		drain_core();
		write_reg(REG_PARALLEL, $urandom);
		write_reg(REG_OVERLAP, $urandom);
		write_reg(REG_COPLANAR, $urandom);
		run_random_pairs(PHASE_PAIRS);

		drain_core();
		if (errors == 0 && pending_points.size() == 0) begin
			$display("tb_ray_ray_intersection_core passed");
		end else begin
			$display("tb_ray_ray_intersection_core failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rri_pkg.sv
rtl/core/rri_geom.sv
rtl/core/rri_div_step.sv
rtl/core/ray_ray_intersection_core.sv
test/tb_ray_ray_intersection_core.sv
